// File: src/lfu_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lfu_pkg;

    localparam int ENTRIES_DEF    = 16;
    localparam int COUNT_BITS_DEF = 16;
    localparam int TAG_W          = 64;
    localparam int TIME_W         = 32;
    localparam int ORDER_W        = 32;
    localparam int OP_W           = 3;
    localparam int CAP_W          = 5;
    localparam int UCOUNT_W       = 16;
    localparam int CFG_IDX_W      = 1;

    localparam logic [OP_W-1:0] OP_LOOKUP    = 3'd0;
    localparam logic [OP_W-1:0] OP_INSERT    = 3'd1;
    localparam logic [OP_W-1:0] OP_EVICTABLE = 3'd2;
    localparam logic [OP_W-1:0] OP_EVICT     = 3'd3;
    localparam logic [OP_W-1:0] OP_REMOVE    = 3'd4;

    localparam logic [CFG_IDX_W-1:0] REG_CAPACITY  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_FRESHNESS = 1'b1;

    typedef struct packed {
        logic start;
        logic scan_clear;
        logic scan_step;
        logic apply;
        logic out_load;
    } lfu_cmd_t;

    typedef struct packed {
        logic scan_last;
    } lfu_status_t;

endpackage

`default_nettype wire

// File: src/lfu_cache_replacement_with_freshness_core.sv
`timescale 1ns / 1ps
`default_nettype none

// LFU replacement policy with freshness protection for up to ENTRIES tags. Every
// request is captured on acceptance, then a sequential scan of the table entries
// finds the tag, the first free slot and the oldest stale lowest-count entry, and
// then the table is updated and the result loaded once the output register is free.
// Requests are handled one at a time; in_stall is low only while idle.

module lfu_cache_replacement_with_freshness_core
#(
    parameter int ENTRIES    = lfu_pkg::ENTRIES_DEF,
    parameter int COUNT_BITS = lfu_pkg::COUNT_BITS_DEF
)
(
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_valid,
    output logic                                  in_stall,
    input  wire logic [lfu_pkg::OP_W-1:0]         operation,
    input  wire logic [lfu_pkg::TAG_W-1:0]        name_tag,
    input  wire logic [15:0]                      candidate_count,
    input  wire logic [lfu_pkg::TIME_W-1:0]       now_ms,
    output logic                                  out_valid,
    input  wire logic                             out_stall,
    output logic                                  hit,
    output logic                                  full_res,
    output logic                                  evictable,
    output logic                                  evicted,
    output logic [lfu_pkg::TAG_W-1:0]             evicted_tag,
    output logic [lfu_pkg::UCOUNT_W-1:0]          use_count,
    output logic                                  refused,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [lfu_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [31:0]                      cfg_data
);

    lfu_pkg::lfu_cmd_t              cmd;
    lfu_pkg::lfu_status_t           status;
    logic [lfu_pkg::CAP_W-1:0]      capacity_reg;
    logic [lfu_pkg::TIME_W-1:0]     freshness_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg  <= lfu_pkg::CAP_W'(16);
            freshness_reg <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                lfu_pkg::REG_CAPACITY:  capacity_reg  <= cfg_data[lfu_pkg::CAP_W-1:0];
                lfu_pkg::REG_FRESHNESS: freshness_reg <= cfg_data;
                default:                freshness_reg <= freshness_reg;
            endcase
        end
    end

    lfu_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    lfu_datapath #(
        .ENTRIES    (ENTRIES),
        .COUNT_BITS (COUNT_BITS)
    ) u_datapath
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .operation       (operation),
        .name_tag        (name_tag),
        .candidate_count (candidate_count),
        .now_ms          (now_ms),
        .capacity        (capacity_reg),
        .freshness_limit (freshness_reg),
        .hit             (hit),
        .full_res        (full_res),
        .evictable       (evictable),
        .evicted         (evicted),
        .evicted_tag     (evicted_tag),
        .use_count       (use_count),
        .refused         (refused)
    );

endmodule

`default_nettype wire

// File: src/lfu_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module lfu_ctrl
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_stall,
    output logic                     out_valid,
    input  wire logic                out_stall,
    input  wire lfu_pkg::lfu_status_t status,
    output lfu_pkg::lfu_cmd_t        cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_APPLY,
        ST_OUT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   accept;

    assign in_stall  = (state_reg != ST_IDLE);
    assign accept    = in_valid && !in_stall;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next       = state_reg;
        out_valid_next   = out_valid_reg;
        cmd              = '0;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd.start      = 1'b1;
                    cmd.scan_clear = 1'b1;
                    state_next     = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (status.scan_last)
                begin
                    state_next = ST_APPLY;
                end
            end
            ST_APPLY:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.apply      = 1'b1;
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            ST_OUT:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

// File: src/lfu_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module lfu_datapath
#(
    parameter int ENTRIES    = lfu_pkg::ENTRIES_DEF,
    parameter int COUNT_BITS = lfu_pkg::COUNT_BITS_DEF
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire lfu_pkg::lfu_cmd_t             cmd,
    output lfu_pkg::lfu_status_t               status,
    input  wire logic [lfu_pkg::OP_W-1:0]      operation,
    input  wire logic [lfu_pkg::TAG_W-1:0]     name_tag,
    input  wire logic [15:0]                   candidate_count,
    input  wire logic [lfu_pkg::TIME_W-1:0]    now_ms,
    input  wire logic [lfu_pkg::CAP_W-1:0]     capacity,
    input  wire logic [lfu_pkg::TIME_W-1:0]    freshness_limit,
    output logic                               hit,
    output logic                               full_res,
    output logic                               evictable,
    output logic                               evicted,
    output logic [lfu_pkg::TAG_W-1:0]          evicted_tag,
    output logic [lfu_pkg::UCOUNT_W-1:0]       use_count,
    output logic                               refused
);

    localparam int IDX_W = $clog2(ENTRIES);
    localparam int OCC_W = $clog2(ENTRIES + 1);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    logic [ENTRIES-1:0]            valid_reg;
    logic [lfu_pkg::TAG_W-1:0]     tag_mem   [ENTRIES];
    logic [COUNT_BITS-1:0]         count_mem [ENTRIES];
    logic [lfu_pkg::TIME_W-1:0]    stamp_mem [ENTRIES];
    logic [lfu_pkg::ORDER_W-1:0]   order_mem [ENTRIES];
    logic [lfu_pkg::ORDER_W-1:0]   order_cnt_reg;
    logic [OCC_W-1:0]              occ_reg;

    logic [lfu_pkg::OP_W-1:0]      op_reg;
    logic [lfu_pkg::TAG_W-1:0]     tag_reg;
    logic [15:0]                   cand_reg;
    logic [lfu_pkg::TIME_W-1:0]    now_reg;

    logic [IDX_W-1:0]              idx_reg;
    logic                          match_reg;
    logic [IDX_W-1:0]              match_idx_reg;
    logic                          free_reg;
    logic [IDX_W-1:0]              free_idx_reg;
    logic                          any_reg;
    logic [COUNT_BITS-1:0]         min_reg;
    logic                          vic_reg;
    logic [IDX_W-1:0]              vic_idx_reg;
    logic [lfu_pkg::ORDER_W-1:0]   vic_age_reg;

    logic                          e_valid;
    logic [COUNT_BITS-1:0]         e_count;
    logic                          e_stale;
    logic [lfu_pkg::ORDER_W-1:0]   e_age;
    logic                          table_full;
    logic [OCC_W-1:0]              occ_after;
    logic                          full_after;
    logic [COUNT_BITS-1:0]         inc_count;

    assign e_valid = valid_reg[idx_reg];
    assign e_count = count_mem[idx_reg];
    assign e_stale = (now_reg - stamp_mem[idx_reg]) >= freshness_limit;
    assign e_age   = order_cnt_reg - order_mem[idx_reg];
    assign status.scan_last = (idx_reg == IDX_W'(ENTRIES - 1));

    assign table_full = ({{(32-OCC_W){1'b0}}, occ_reg} >= {27'd0, capacity})
                        || (occ_reg == OCC_W'(ENTRIES));
    assign inc_count  = (count_mem[match_idx_reg] < COUNT_MAX)
                        ? count_mem[match_idx_reg] + 1'b1 : count_mem[match_idx_reg];

    // One entry per cycle: tag match, first free slot, and the running minimum
    // with its oldest stale holder, restarted whenever a lower count shows up.
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            op_reg   <= operation;
            tag_reg  <= name_tag;
            cand_reg <= candidate_count;
            now_reg  <= now_ms;
        end
        if (cmd.scan_clear)
        begin
            idx_reg   <= '0;
            match_reg <= 1'b0;
            free_reg  <= 1'b0;
            any_reg   <= 1'b0;
            vic_reg   <= 1'b0;
        end
        else if (cmd.scan_step)
        begin
            idx_reg <= idx_reg + 1'b1;
            if (e_valid && tag_mem[idx_reg] == tag_reg && !match_reg)
            begin
                match_reg     <= 1'b1;
                match_idx_reg <= idx_reg;
            end
            if (!e_valid && !free_reg)
            begin
                free_reg     <= 1'b1;
                free_idx_reg <= idx_reg;
            end
            if (e_valid)
            begin
                if (!any_reg || e_count < min_reg)
                begin
                    any_reg     <= 1'b1;
                    min_reg     <= e_count;
                    vic_reg     <= e_stale;
                    vic_idx_reg <= idx_reg;
                    vic_age_reg <= e_age;
                end
                else if (e_count == min_reg && e_stale && (!vic_reg || e_age > vic_age_reg))
                begin
                    vic_reg     <= 1'b1;
                    vic_idx_reg <= idx_reg;
                    vic_age_reg <= e_age;
                end
            end
        end
    end

    always_comb
    begin
        occ_after = occ_reg;
        case (op_reg)
            lfu_pkg::OP_INSERT:
            begin
                if (!match_reg && !table_full)
                begin
                    occ_after = occ_reg + 1'b1;
                end
            end
            lfu_pkg::OP_EVICT:
            begin
                if (any_reg && vic_reg)
                begin
                    occ_after = occ_reg - 1'b1;
                end
            end
            lfu_pkg::OP_REMOVE:
            begin
                if (match_reg)
                begin
                    occ_after = occ_reg - 1'b1;
                end
            end
            default:
            begin
                occ_after = occ_reg;
            end
        endcase
        full_after = ({{(32-OCC_W){1'b0}}, occ_after} >= {27'd0, capacity})
                     || (occ_after == OCC_W'(ENTRIES));
    end

    always_ff @(posedge clk)
    begin
        if (cmd.apply)
        begin
            if (op_reg == lfu_pkg::OP_LOOKUP && match_reg)
            begin
                count_mem[match_idx_reg] <= inc_count;
                order_mem[match_idx_reg] <= order_cnt_reg;
            end
            if (op_reg == lfu_pkg::OP_INSERT && !match_reg && !table_full)
            begin
                tag_mem[free_idx_reg]   <= tag_reg;
                count_mem[free_idx_reg] <= COUNT_BITS'(1);
                stamp_mem[free_idx_reg] <= now_reg;
                order_mem[free_idx_reg] <= order_cnt_reg;
            end
        end
        if (cmd.out_load)
        begin
            hit         <= 1'b0;
            evictable   <= 1'b0;
            evicted     <= 1'b0;
            evicted_tag <= '0;
            use_count   <= '0;
            refused     <= 1'b0;
            full_res    <= full_after;
            case (op_reg)
                lfu_pkg::OP_LOOKUP:
                begin
                    hit <= match_reg;
                    if (match_reg)
                    begin
                        use_count <= lfu_pkg::UCOUNT_W'({{32{1'b0}}, inc_count});
                    end
                end
                lfu_pkg::OP_INSERT:
                begin
                    hit     <= match_reg;
                    refused <= match_reg || table_full;
                end
                lfu_pkg::OP_EVICTABLE:
                begin
                    evictable <= !any_reg || ({16'd0, cand_reg} >= 32'(min_reg)) || vic_reg;
                end
                lfu_pkg::OP_EVICT:
                begin
                    if (any_reg && vic_reg)
                    begin
                        evicted     <= 1'b1;
                        evicted_tag <= tag_mem[vic_idx_reg];
                    end
                end
                lfu_pkg::OP_REMOVE:
                begin
                    if (match_reg)
                    begin
                        hit         <= 1'b1;
                        evicted     <= 1'b1;
                        evicted_tag <= tag_mem[match_idx_reg];
                    end
                end
                default:
                begin
                    hit <= 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            order_cnt_reg <= '0;
            occ_reg       <= '0;
        end
        else if (cmd.apply)
        begin
            occ_reg <= occ_after;
            case (op_reg)
                lfu_pkg::OP_LOOKUP:
                begin
                    if (match_reg)
                    begin
                        order_cnt_reg <= order_cnt_reg + 1'b1;
                    end
                end
                lfu_pkg::OP_INSERT:
                begin
                    if (!match_reg && !table_full)
                    begin
                        valid_reg[free_idx_reg] <= 1'b1;
                        order_cnt_reg           <= order_cnt_reg + 1'b1;
                    end
                end
                lfu_pkg::OP_EVICT:
                begin
                    if (any_reg && vic_reg)
                    begin
                        valid_reg[vic_idx_reg] <= 1'b0;
                    end
                end
                lfu_pkg::OP_REMOVE:
                begin
                    if (match_reg)
                    begin
                        valid_reg[match_idx_reg] <= 1'b0;
                    end
                end
                default:
                begin
                    order_cnt_reg <= order_cnt_reg;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// File: verif/lfu_cache_replacement_with_freshness_core_test.sv
`timescale 1ns / 1ps

module lfu_cache_replacement_with_freshness_core_test;
    import lfu_pkg::*;

    localparam int SLOTS = 16;
    localparam int COUNT_CEIL = 65535;
    localparam int TAG_POOL = 24;
    localparam int STALL_LIMIT = 5000;
    localparam logic [OP_W-1:0] OP_SPARE_LO = OP_REMOVE + 3'd1;
    localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

    typedef struct {
        bit        hit;
        bit        full;
        bit        evictable;
        bit        evicted;
        bit [63:0] etag;
        bit [15:0] ucount;
        bit        refused;
    } lfu_result_t;

    class freshness_scoreboard;
        bit          slot_valid[SLOTS];
        bit [63:0]   slot_tag[SLOTS];
        int unsigned slot_count[SLOTS];
        bit [31:0]   slot_stamp[SLOTS];
        bit [31:0]   slot_order[SLOTS];
        bit [31:0]   order_ctr;
        bit [4:0]    capacity;
        bit [31:0]   fresh_ms;
        lfu_result_t pending[$];
        int          errors;
        int          requests;
        int          results;

        function void clear_state();
            foreach (slot_valid[i]) slot_valid[i] = 0;
            order_ctr = 0;
            capacity = 5'd16;
            fresh_ms = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
            if (idx == REG_CAPACITY)
                capacity = data[4:0];
            else
                fresh_ms = data;
        endfunction

        function int find_slot(bit [63:0] tag);
            for (int i = 0; i < SLOTS; i++)
                if (slot_valid[i] && slot_tag[i] == tag)
                    return i;
            return -1;
        endfunction

        function bit table_full();
            int n;
            n = 0;
            foreach (slot_valid[i]) n += slot_valid[i];
            return n >= capacity || n >= SLOTS;
        endfunction

        function bit lowest_count(output int unsigned m);
            bit any;
            any = 0;
            m = 0;
            for (int i = 0; i < SLOTS; i++)
                if (slot_valid[i] && (!any || slot_count[i] < m))
                begin
                    m = slot_count[i];
                    any = 1;
                end
            return any;
        endfunction

        function int stale_victim(int unsigned m, bit [31:0] now);
            int best;
            bit [31:0] best_age;
            bit [31:0] age;
            best = -1;
            best_age = 0;
            for (int i = 0; i < SLOTS; i++)
            begin
                if (!slot_valid[i] || slot_count[i] != m)
                    continue;
                age = now - slot_stamp[i];
                if (age < fresh_ms)
                    continue;
                age = order_ctr - slot_order[i];
                if (best < 0 || age > best_age)
                begin
                    best = i;
                    best_age = age;
                end
            end
            return best;
        endfunction

        function void note_request(logic [OP_W-1:0] op, logic [63:0] tag,
                                   logic [15:0] cand, logic [31:0] now);
            lfu_result_t r;
            int k;
            int unsigned m;
            r = '{default: 0};
            requests++;
            case (op)
                OP_LOOKUP:
                begin
                    k = find_slot(tag);
                    if (k >= 0)
                    begin
                        r.hit = 1;
                        if (slot_count[k] < COUNT_CEIL)
                            slot_count[k]++;
                        slot_order[k] = order_ctr++;
                        r.ucount = slot_count[k][15:0];
                    end
                end
                OP_INSERT:
                begin
                    if (find_slot(tag) >= 0)
                    begin
                        r.hit = 1;
                        r.refused = 1;
                    end
                    else if (table_full())
                        r.refused = 1;
                    else
                    begin
                        for (int i = 0; i < SLOTS; i++)
                            if (!slot_valid[i])
                            begin
                                slot_valid[i] = 1;
                                slot_tag[i] = tag;
                                slot_count[i] = 1;
                                slot_stamp[i] = now;
                                slot_order[i] = order_ctr++;
                                break;
                            end
                    end
                end
                OP_EVICTABLE:
                begin
                    if (!lowest_count(m))
                        r.evictable = 1;
                    else if (cand >= m)
                        r.evictable = 1;
                    else if (stale_victim(m, now) >= 0)
                        r.evictable = 1;
                end
                OP_EVICT:
                begin
                    if (lowest_count(m))
                    begin
                        k = stale_victim(m, now);
                        if (k >= 0)
                        begin
                            r.evicted = 1;
                            r.etag = slot_tag[k];
                            slot_valid[k] = 0;
                        end
                    end
                end
                OP_REMOVE:
                begin
                    k = find_slot(tag);
                    if (k >= 0)
                    begin
                        r.hit = 1;
                        r.evicted = 1;
                        r.etag = slot_tag[k];
                        slot_valid[k] = 0;
                    end
                end
                default:
                    ;
            endcase
            r.full = table_full();
            pending.push_back(r);
        endfunction

        function void compare(string fname, bit [63:0] e, bit [63:0] a);
            if (e !== a)
            begin
                errors++;
                $display("%0t: %s mismatch, expected %h, actual %h", $time, fname, e, a);
            end
        endfunction

        function void check_result(lfu_result_t act);
            lfu_result_t e;
            results++;
            if (pending.size() == 0)
            begin
                errors++;
                $display("%0t: result with no request outstanding", $time);
                return;
            end
            e = pending.pop_front();
            compare("hit", e.hit, act.hit);
            compare("full_res", e.full, act.full);
            compare("evictable", e.evictable, act.evictable);
            compare("evicted", e.evicted, act.evicted);
            compare("evicted_tag", e.etag, act.etag);
            compare("use_count", e.ucount, act.ucount);
            compare("refused", e.refused, act.refused);
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    logic [OP_W-1:0] operation;
    logic [TAG_W-1:0] name_tag;
    logic [15:0] candidate_count;
    logic [TIME_W-1:0] now_ms;
    logic out_valid;
    logic out_stall;
    logic hit;
    logic full_res;
    logic evictable;
    logic evicted;
    logic [TAG_W-1:0] evicted_tag;
    logic [UCOUNT_W-1:0] use_count;
    logic refused;
    logic cfg_valid;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [31:0] cfg_data;

    freshness_scoreboard sb = new;
    logic [63:0] tag_pool[TAG_POOL];
    logic [31:0] clock_ms;
    bit quiet;
    int stall_left;
    int idle_cycles;
    int settings_used;

    lfu_cache_replacement_with_freshness_core uut
    (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .operation(operation),
        .name_tag(name_tag),
        .candidate_count(candidate_count),
        .now_ms(now_ms),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .hit(hit),
        .full_res(full_res),
        .evictable(evictable),
        .evicted(evicted),
        .evicted_tag(evicted_tag),
        .use_count(use_count),
        .refused(refused),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 4);
        return $urandom_range(10, 60);
    endfunction

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    always @(posedge clk)
    begin
        lfu_result_t act;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                sb.note_request(operation, name_tag, candidate_count, now_ms);
            if (out_valid && !out_stall)
            begin
                act.hit = hit;
                act.full = full_res;
                act.evictable = evictable;
                act.evicted = evicted;
                act.etag = evicted_tag;
                act.ucount = use_count;
                act.refused = refused;
                sb.check_result(act);
            end
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("FAIL lfu_cache_replacement_with_freshness_core");
                $finish;
            end
        end
    end

    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            out_stall <= 1'b1;
            stall_left <= stall_left - 1;
        end
        else
        begin
            out_stall <= 1'b0;
            if (!quiet && $urandom_range(0, 99) < 15)
                stall_left <= pick_gap();
        end
    end

    task automatic send(input logic [OP_W-1:0] op, input logic [63:0] tag,
                        input logic [15:0] cand);
        int gap;
        in_valid <= 1'b1;
        operation <= op;
        name_tag <= tag;
        candidate_count <= cand;
        now_ms <= clock_ms;
        do
            @(posedge clk);
        while (in_stall);
        gap = quiet ? 0 : pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.set_reg(idx, data);
        settings_used++;
    endtask

    task automatic random_request();
        int r;
        logic [63:0] tag;
        logic [15:0] cand;
        r = $urandom_range(0, 99);
        tag = ($urandom_range(0, 19) == 0) ? {$urandom, $urandom}
                                           : tag_pool[$urandom_range(0, TAG_POOL - 1)];
        cand = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 4));
        if ($urandom_range(0, 49) == 0)
            clock_ms = $urandom;
        else
            clock_ms = clock_ms + $urandom_range(0, 30);
        if (r < 35)
            send(OP_INSERT, tag, cand);
        else if (r < 65)
            send(OP_LOOKUP, tag, cand);
        else if (r < 77)
            send(OP_EVICTABLE, tag, cand);
        else if (r < 88)
            send(OP_EVICT, tag, cand);
        else if (r < 97)
            send(OP_REMOVE, tag, cand);
        else
            send(3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI)), tag, cand);
    endtask

    initial
    begin
        logic [31:0] cap_set[8];
        logic [31:0] fresh_set[8];
        in_valid = 1'b0;
        operation = OP_LOOKUP;
        name_tag = '0;
        candidate_count = '0;
        now_ms = '0;
        out_stall = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_CAPACITY;
        cfg_data = '0;
        quiet = 1'b0;
        stall_left = 0;
        idle_cycles = 0;
        settings_used = 0;
        clock_ms = 0;
        sb.clear_state();
        foreach (tag_pool[i]) tag_pool[i] = {$urandom, $urandom};
        rst_n = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send(OP_EVICTABLE, 64'd0, 16'd0);
        send(OP_EVICT, 64'd0, 16'hFFFF);
        send(OP_INSERT, 64'd0, 16'd0);
        clock_ms = 32'hFFFF_FFFF;
        send(OP_INSERT, '1, 16'd0);
        send(OP_INSERT, 64'd0, 16'd0);
        send(OP_LOOKUP, 64'd0, 16'd0);
        send(OP_LOOKUP, 64'd5, 16'd0);
        send(OP_EVICTABLE, 64'd0, 16'd0);
        send(OP_EVICTABLE, 64'd0, 16'hFFFF);
        send(OP_REMOVE, '1, 16'd0);
        send(OP_REMOVE, 64'd5, 16'd0);
        send(OP_SPARE_HI, '1, 16'hFFFF);
        send(OP_EVICT, 64'd0, 16'd0);
        drain();
        write_reg(REG_CAPACITY, 32'd2);
        write_reg(REG_FRESHNESS, 32'd100);
        clock_ms = 32'd1000;
        send(OP_INSERT, tag_pool[0], 16'd0);
        send(OP_INSERT, tag_pool[1], 16'd0);
        send(OP_INSERT, tag_pool[2], 16'd0);
        send(OP_LOOKUP, tag_pool[0], 16'd0);
        send(OP_EVICT, 64'd0, 16'd0);
        send(OP_EVICTABLE, 64'd0, 16'd0);
        clock_ms = 32'd1100;
        send(OP_EVICTABLE, 64'd0, 16'd0);
        send(OP_EVICT, 64'd0, 16'd0);
        send(OP_REMOVE, tag_pool[0], 16'd0);
        drain();

        // Raise one entry's count, the only one in the table, with back-to-back lookups.
        write_reg(REG_CAPACITY, 32'd16);
        quiet = 1'b1;
        send(OP_INSERT, tag_pool[3], 16'd0);
        repeat (20) send(OP_LOOKUP, tag_pool[3], 16'd0);
        send(OP_EVICTABLE, 64'd0, 16'hFFFE);
        send(OP_REMOVE, tag_pool[3], 16'd0);
        quiet = 1'b0;
        drain();

        cap_set = '{32'd16, 32'd1, 32'd4, 32'd0, 32'd31, 32'd8, 32'd16, 32'd12};
        fresh_set = '{32'd0, 32'd50, 32'hFFFF_FFFF, 32'd10, 32'd0, 32'd200, 32'd25, 32'd0};
        for (int p = 0; p < 8; p++)
        begin
            write_reg(REG_CAPACITY, cap_set[p]);
            write_reg(REG_FRESHNESS, p == 7 ? $urandom : fresh_set[p]);
            quiet = (p == 2);
            for (int n = 0; n < 125; n++)
            begin
                random_request();
                if (p == 4 && n == 60)
                begin
                    in_valid <= 1'b0;
                    while (sb.pending.size() != 0)
                        @(posedge clk);
                end
            end
            drain();
        end

        $display("Covered %0d requests and %0d results over %0d register writes,",
                 sb.requests, sb.results, settings_used);
        $display("including repeated lookups, full-table refusal and stale eviction.");
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("PASS lfu_cache_replacement_with_freshness_core");
        else
            $display("FAIL lfu_cache_replacement_with_freshness_core");
        $finish;
    end

endmodule
